>>> sv/dit_pkg.sv
// Types, codes and helpers shared by the diagnostic identifier table.
// No dependencies; compiled first.
package dit_pkg;

  localparam int unsigned NUM_ENTRIES_DEF    = 16;
  localparam int unsigned MAX_DATA_BYTES_DEF = 8;
  localparam int unsigned LIST_DEPTH_DEF     = 16;

  localparam logic [7:0] SID_READ      = 8'h62;
  localparam logic [7:0] SID_WRITE     = 8'h6E;
  localparam logic [7:0] NRC_NONE      = 8'h00;
  localparam logic [7:0] NRC_RANGE     = 8'h31;
  localparam logic [7:0] NRC_SECURITY  = 8'h33;
  localparam logic [7:0] NRC_LENGTH    = 8'h13;
  localparam logic [9:0] WR_RESP_BYTES = 10'd3;
  localparam logic [2:0] DID_BYTES     = 3'd2;

  localparam logic [2:0] STAT_OK       = 3'd0;
  localparam logic [2:0] STAT_RANGE    = 3'd1;
  localparam logic [2:0] STAT_SECURITY = 3'd2;
  localparam logic [2:0] STAT_LENGTH   = 3'd3;
  localparam logic [2:0] STAT_TOO_LONG = 3'd4;

  localparam logic [1:0] CFG_ENTRIES  = 2'd0;
  localparam logic [1:0] CFG_SESSION  = 2'd1;
  localparam logic [1:0] CFG_SECURITY = 2'd2;
  localparam logic [1:0] CFG_LIMIT    = 2'd3;

  typedef enum logic [1:0] {
    KIND_DEFINE = 2'd0,
    KIND_READ   = 2'd1,
    KIND_WRITE  = 2'd2,
    KIND_NONE   = 2'd3
  } kind_e;

  typedef struct packed {
    logic [1:0]  kind;
    logic [3:0]  slot;
    logic [15:0] did_id;
    logic [3:0]  byte_cnt;
    logic [63:0] data_word;
    logic        writable;
    logic [7:0]  min_session;
    logic        needs_security;
    logic        last;
  } item_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [7:0]  nrc_code;
    logic [7:0]  response_sid;
    logic [15:0] did_id_res;
    logic [3:0]  data_len_res;
    logic [63:0] data_word_res;
    logic [9:0]  response_bytes;
    logic        last_res;
  } res_t;

  typedef struct packed {
    logic [4:0] entries_in_use;
    logic [7:0] session_level;
    logic       sec_unlock;
    logic [9:0] response_limit;
  } cfg_t;

  function automatic logic [63:0] byte_mask(input logic [3:0] len);
    logic [63:0] m;
    if (len >= 4'd8) begin
      m = '1;
    end else begin
      m = (64'd1 << {len, 3'b000}) - 64'd1;
    end
    return m;
  endfunction

endpackage

>>> sv/dit_if.sv
// Handshake channels of the diagnostic identifier table.
// Depends on dit_pkg.
interface dit_item_if;
  import dit_pkg::*;
  logic  valid;
  logic  ready;
  item_t item;
  modport source (output valid, output item, input ready);
  modport sink   (input valid, input item, output ready);
endinterface

interface dit_res_if;
  import dit_pkg::*;
  logic valid;
  logic ready;
  res_t res;
  modport source (output valid, output res, input ready);
  modport sink   (input valid, input res, output ready);
endinterface

interface dit_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [31:0] wdata;
  modport source (output valid, output index, output wdata, input ready);
  modport sink   (input valid, input index, input wdata, output ready);
endinterface

>>> sv/dit_front.sv
// Front end: accepts request items, drops unknown kinds, queues two deep.
// Depends on dit_pkg and dit_if.
module dit_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  dit_item_if.sink           req,
  output logic               head_valid_o,
  output dit_pkg::item_t     head_o,
  input  logic               pop_i
);
  import dit_pkg::*;

  item_t      q_q [2];
  logic       wp_q, rp_q;
  logic [1:0] cnt_q;
  logic       push;

  assign req.ready    = (cnt_q != 2'd2);
  assign push         = req.valid && req.ready && (kind_e'(req.item.kind) != KIND_NONE);
  assign head_valid_o = (cnt_q != 2'd0);
  assign head_o       = q_q[rp_q];

  always_ff @(posedge clk_i) begin
    if (push) begin
      q_q[wp_q] <= req.item;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push) wp_q <= ~wp_q;
      if (pop_i) rp_q <= ~rp_q;
      cnt_q <= cnt_q + 2'(push) - 2'(pop_i);
    end
  end

endmodule

>>> sv/dit_back.sv
// Back end: table store, read list, slot scan sequencer and result register.
// Depends on dit_pkg and dit_if.
module dit_back #(
  parameter int unsigned NUM_ENTRIES    = dit_pkg::NUM_ENTRIES_DEF,
  parameter int unsigned MAX_DATA_BYTES = dit_pkg::MAX_DATA_BYTES_DEF,
  parameter int unsigned LIST_DEPTH     = dit_pkg::LIST_DEPTH_DEF
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           head_valid_i,
  input  dit_pkg::item_t head_i,
  output logic           pop_o,
  input  dit_pkg::cfg_t  cfg_i,
  dit_res_if.source      rsp
);
  import dit_pkg::*;

  localparam int unsigned IW  = (NUM_ENTRIES > 1) ? $clog2(NUM_ENTRIES) : 1;
  localparam int unsigned JW0 = $clog2(NUM_ENTRIES + 1);
  localparam int unsigned EW  = (JW0 > 5) ? JW0 : 5;
  localparam int unsigned LW  = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
  localparam int unsigned CW  = $clog2(LIST_DEPTH + 1);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_SCAN = 1'b1;

  logic [15:0] ids_q  [NUM_ENTRIES];
  logic [63:0] data_q [NUM_ENTRIES];
  logic [3:0]  len_q  [NUM_ENTRIES];
  logic        wr_q   [NUM_ENTRIES];
  logic [7:0]  mins_q [NUM_ENTRIES];
  logic        sec_q  [NUM_ENTRIES];
  logic [15:0] list_q [LIST_DEPTH];

  logic          state_q, state_d;
  item_t         cur_q, cur_d;
  logic [EW-1:0] j_q, j_d;
  logic [LW-1:0] idx_q, idx_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic          ovf_q, ovf_d;
  logic          phase_q, phase_d;
  logic [10:0]   pos_q, pos_d;
  logic          ov_q;
  res_t          ores_q, res_d;

  logic          out_free, emit, def_we, list_we, commit;
  logic [EW-1:0] n;
  logic [IW-1:0] jx;
  logic [15:0]   key;
  logic          miss, hit, is_last;
  logic [10:0]   newpos;
  logic [3:0]    def_len;

  assign out_free  = !ov_q || rsp.ready;
  assign rsp.valid = ov_q;
  assign rsp.res   = ores_q;

  assign n = (EW'(cfg_i.entries_in_use) > EW'(NUM_ENTRIES)) ? EW'(NUM_ENTRIES)
                                                           : EW'(cfg_i.entries_in_use);
  assign jx      = j_q[IW-1:0];
  assign key     = (kind_e'(cur_q.kind) == KIND_WRITE) ? cur_q.did_id : list_q[idx_q];
  assign miss    = (j_q == n);
  assign hit     = !miss && (ids_q[jx] == key);
  assign newpos  = pos_q + 11'(DID_BYTES) + 11'(len_q[jx]);
  assign is_last = (CW'(idx_q) + CW'(1) == cnt_q);
  assign def_len = (32'(head_i.byte_cnt) > MAX_DATA_BYTES) ? 4'(MAX_DATA_BYTES)
                                                           : head_i.byte_cnt;

  always_comb begin
    state_d = state_q;
    cur_d   = cur_q;
    j_d     = j_q;
    idx_d   = idx_q;
    cnt_d   = cnt_q;
    ovf_d   = ovf_q;
    phase_d = phase_q;
    pos_d   = pos_q;
    pop_o   = 1'b0;
    emit    = 1'b0;
    def_we  = 1'b0;
    list_we = 1'b0;
    commit  = 1'b0;
    res_d   = '0;
    res_d.last_res = 1'b1;
    case (state_q)
      S_IDLE: begin
        if (head_valid_i && out_free) begin
          pop_o = 1'b1;
          cur_d = head_i;
          case (kind_e'(head_i.kind))
            KIND_DEFINE: def_we = 1'b1;
            KIND_READ: begin
              if (32'(cnt_q) < LIST_DEPTH) begin
                list_we = 1'b1;
                cnt_d   = cnt_q + CW'(1);
              end else begin
                ovf_d = 1'b1;
              end
              if (head_i.last) begin
                if (ovf_d || cfg_i.response_limit == 10'd0) begin
                  emit         = 1'b1;
                  res_d.status = STAT_TOO_LONG;
                  cnt_d        = '0;
                  ovf_d        = 1'b0;
                end else begin
                  state_d = S_SCAN;
                  idx_d   = '0;
                  j_d     = '0;
                  pos_d   = 11'd1;
                  phase_d = 1'b0;
                end
              end
            end
            KIND_WRITE: begin
              state_d = S_SCAN;
              j_d     = '0;
            end
            default: ;
          endcase
        end
      end
      S_SCAN: begin
        res_d.did_id_res = key;
        if (miss) begin
          if (out_free) begin
            emit           = 1'b1;
            res_d.status   = STAT_RANGE;
            res_d.nrc_code = NRC_RANGE;
            state_d        = S_IDLE;
            if (kind_e'(cur_q.kind) == KIND_READ) begin
              cnt_d = '0;
              ovf_d = 1'b0;
            end
          end
        end else if (hit) begin
          if (kind_e'(cur_q.kind) == KIND_WRITE) begin
            if (out_free) begin
              emit    = 1'b1;
              state_d = S_IDLE;
              if (!wr_q[jx] || cfg_i.session_level < mins_q[jx]) begin
                res_d.status   = STAT_RANGE;
                res_d.nrc_code = NRC_RANGE;
              end else if (sec_q[jx] && !cfg_i.sec_unlock) begin
                res_d.status   = STAT_SECURITY;
                res_d.nrc_code = NRC_SECURITY;
              end else if (cur_q.byte_cnt != len_q[jx]) begin
                res_d.status   = STAT_LENGTH;
                res_d.nrc_code = NRC_LENGTH;
              end else if (cfg_i.response_limit < WR_RESP_BYTES) begin
                res_d.status = STAT_TOO_LONG;
              end else begin
                commit               = 1'b1;
                res_d.response_sid   = SID_WRITE;
                res_d.response_bytes = WR_RESP_BYTES;
              end
            end
          end else if (!phase_q) begin
            if (newpos > {1'b0, cfg_i.response_limit}) begin
              if (out_free) begin
                emit         = 1'b1;
                res_d.status = STAT_TOO_LONG;
                state_d      = S_IDLE;
                cnt_d        = '0;
                ovf_d        = 1'b0;
              end
            end else begin
              pos_d = newpos;
              j_d   = '0;
              if (is_last) begin
                phase_d = 1'b1;
                idx_d   = '0;
              end else begin
                idx_d = idx_q + LW'(1);
              end
            end
          end else if (out_free) begin
            emit                = 1'b1;
            res_d.response_sid  = SID_READ;
            res_d.data_len_res  = len_q[jx];
            res_d.data_word_res = data_q[jx];
            res_d.last_res      = is_last;
            if (is_last) begin
              res_d.response_bytes = pos_q[9:0];
              state_d              = S_IDLE;
              cnt_d                = '0;
              ovf_d                = 1'b0;
            end else begin
              idx_d = idx_q + LW'(1);
              j_d   = '0;
            end
          end
        end else begin
          j_d = j_q + EW'(1);
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_ENTRIES; i++) begin
        ids_q[i]  <= '0;
        data_q[i] <= '0;
        len_q[i]  <= '0;
        wr_q[i]   <= 1'b0;
        mins_q[i] <= '0;
        sec_q[i]  <= 1'b0;
      end
    end else begin
      if (def_we && (32'(head_i.slot) < NUM_ENTRIES)) begin
        ids_q[IW'(head_i.slot)]  <= head_i.did_id;
        len_q[IW'(head_i.slot)]  <= def_len;
        data_q[IW'(head_i.slot)] <= head_i.data_word & byte_mask(def_len);
        wr_q[IW'(head_i.slot)]   <= head_i.writable;
        mins_q[IW'(head_i.slot)] <= head_i.min_session;
        sec_q[IW'(head_i.slot)]  <= head_i.needs_security;
      end
      if (commit) begin
        data_q[jx] <= cur_q.data_word & byte_mask(cur_q.byte_cnt);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (list_we) begin
      list_q[cnt_q[LW-1:0]] <= head_i.did_id;
    end
    if (emit) begin
      ores_q <= res_d;
    end
    cur_q   <= cur_d;
    j_q     <= j_d;
    idx_q   <= idx_d;
    phase_q <= phase_d;
    pos_q   <= pos_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
      ovf_q   <= 1'b0;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      ovf_q   <= ovf_d;
      if (emit) begin
        ov_q <= 1'b1;
      end else if (rsp.ready) begin
        ov_q <= 1'b0;
      end
    end
  end

endmodule

>>> sv/diagnostic_identifier_table.sv
// Channel  Dir  Role
// req_i    in   define / read / write items (dit_item_if)
// rsp_o    out  result records (dit_res_if)
// cfg_i    in   register writes, index 0..3 (dit_cfg_if)
// Each lookup scans slots one per cycle, up to min(entries_in_use, NUM_ENTRIES) slots
// per identifier; a read list of k ids takes two scans each, a write one scan.
// Define items are written from idle without a scan. A two-deep queue parts intake from the scanner.
// Reset clears the table and control state; rsp_o stalls hold the scanner.
// Depends on dit_pkg, dit_if, dit_front, dit_back.
module diagnostic_identifier_table #(
  parameter int unsigned NUM_ENTRIES    = dit_pkg::NUM_ENTRIES_DEF,
  parameter int unsigned MAX_DATA_BYTES = dit_pkg::MAX_DATA_BYTES_DEF,
  parameter int unsigned LIST_DEPTH     = dit_pkg::LIST_DEPTH_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  dit_item_if.sink   req_i,
  dit_res_if.source  rsp_o,
  dit_cfg_if.sink    cfg_i
);
  import dit_pkg::*;

  cfg_t  cfg_q;
  logic  head_valid, pop;
  item_t head;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.entries_in_use <= 5'd0;
      cfg_q.session_level  <= 8'd1;
      cfg_q.sec_unlock     <= 1'b0;
      cfg_q.response_limit <= 10'd1023;
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        CFG_ENTRIES:  cfg_q.entries_in_use <= cfg_i.wdata[4:0];
        CFG_SESSION:  cfg_q.session_level  <= cfg_i.wdata[7:0];
        CFG_SECURITY: cfg_q.sec_unlock     <= cfg_i.wdata[0];
        CFG_LIMIT:    cfg_q.response_limit <= cfg_i.wdata[9:0];
        default: ;
      endcase
    end
  end

  dit_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .req          (req_i),
    .head_valid_o (head_valid),
    .head_o       (head),
    .pop_i        (pop)
  );

  dit_back #(
    .NUM_ENTRIES    (NUM_ENTRIES),
    .MAX_DATA_BYTES (MAX_DATA_BYTES),
    .LIST_DEPTH     (LIST_DEPTH)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_valid_i (head_valid),
    .head_i       (head),
    .pop_o        (pop),
    .cfg_i        (cfg_q),
    .rsp          (rsp_o)
  );

  a_ok_sid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_o.valid && rsp_o.res.status == STAT_OK |->
      rsp_o.res.response_sid == SID_READ || rsp_o.res.response_sid == SID_WRITE)
    else $error("ok record without response sid");

  a_err_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_o.valid && rsp_o.res.status != STAT_OK |->
      rsp_o.res.last_res && rsp_o.res.data_len_res == 4'd0)
    else $error("error record not final or carries data");

  a_err_sid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_o.valid && rsp_o.res.status != STAT_OK |-> rsp_o.res.response_sid == 8'd0)
    else $error("error record with response sid");

endmodule

>>> tb/sv/dit_tb_if.sv
`timescale 1ns / 1ps
// Testbench-side note: the channel interfaces are those of the RTL (dit_if.sv).
// This file only holds the drain and watchdog constants the testbench relies on.
// Depends on no other file.
package dit_tb_pkg;
  localparam int unsigned DRAIN_CYCLES = 200;
  localparam int unsigned STALL_LIMIT  = 20000;
endpackage

>>> tb/sv/tb_diagnostic_identifier_table.sv
`timescale 1ns / 1ps
// Self-checking bench for diagnostic_identifier_table: builds define/read/write
// traffic, predicts records from a local table model, compares each transfer.
// Depends on dit_pkg, dit_if (RTL), dit_tb_pkg and the RTL top.
module tb_diagnostic_identifier_table;
  import dit_pkg::*;
  import dit_tb_pkg::*;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  dit_item_if req_if ();
  dit_res_if  rsp_if ();
  dit_cfg_if  cfg_if ();

  diagnostic_identifier_table dut (
    .clk_i (clk_i), .rst_ni (rst_ni),
    .req_i (req_if.sink), .rsp_o (rsp_if.source), .cfg_i (cfg_if.sink)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // table model
  logic [15:0] tbl_id   [16];
  logic [63:0] tbl_data [16];
  logic [3:0]  tbl_len  [16];
  logic        tbl_wr   [16];
  logic [7:0]  tbl_ses  [16];
  logic        tbl_sec  [16];
  logic [15:0] pend_ids [$];
  logic        pend_ovf;
  logic [4:0]  m_entries;
  logic [7:0]  m_session;
  logic        m_unlock;
  logic [9:0]  m_limit;

  item_t pending_items [$];
  res_t  expected_recs [$];
  int    mismatches;
  int    stray;
  int    idle_cycles;
  bit    items_done;

  function automatic logic [63:0] mask_len(input int n);
    return (n >= 8) ? '1 : ((64'd1 << (8 * n)) - 64'd1);
  endfunction

  function automatic int lookup_slot(input logic [15:0] id);
    int n;
    n = (m_entries > 16) ? 16 : m_entries;
    for (int i = 0; i < n; i++) if (tbl_id[i] == id) return i;
    return -1;
  endfunction

  function automatic res_t err_rec(input logic [2:0] st, input logic [7:0] nrc,
                                   input logic [15:0] id);
    res_t r;
    r = '0;
    r.status = st; r.nrc_code = nrc; r.did_id_res = id; r.last_res = 1'b1;
    return r;
  endfunction

  task automatic predict_item(input item_t it);
    int s;
    int len;
    int pos;
    bit bad;
    res_t r;
    case (kind_e'(it.kind))
      KIND_DEFINE: begin
        len = (it.byte_cnt > 8) ? 8 : it.byte_cnt;
        tbl_id[it.slot] = it.did_id;
        tbl_len[it.slot] = 4'(len);
        tbl_data[it.slot] = it.data_word & mask_len(len);
        tbl_wr[it.slot] = it.writable;
        tbl_ses[it.slot] = it.min_session;
        tbl_sec[it.slot] = it.needs_security;
      end
      KIND_READ: begin
        if (pend_ids.size() < 16) pend_ids.push_back(it.did_id);
        else pend_ovf = 1'b1;
        if (it.last) begin
          bad = 1'b0;
          pos = 1;
          if (pend_ovf || m_limit < 1) begin
            expected_recs.push_back(err_rec(STAT_TOO_LONG, NRC_NONE, 16'd0));
            bad = 1'b1;
          end else begin
            foreach (pend_ids[i]) begin
              s = lookup_slot(pend_ids[i]);
              if (s < 0) begin
                expected_recs.push_back(err_rec(STAT_RANGE, NRC_RANGE, pend_ids[i]));
                bad = 1'b1;
                break;
              end
              pos += 2 + tbl_len[s];
              if (pos > m_limit) begin
                expected_recs.push_back(err_rec(STAT_TOO_LONG, NRC_NONE, pend_ids[i]));
                bad = 1'b1;
                break;
              end
            end
          end
          if (!bad) begin
            foreach (pend_ids[i]) begin
              s = lookup_slot(pend_ids[i]);
              r = '0;
              r.response_sid = SID_READ;
              r.did_id_res = pend_ids[i];
              r.data_len_res = tbl_len[s];
              r.data_word_res = tbl_data[s] & mask_len(tbl_len[s]);
              if (i == pend_ids.size() - 1) begin
                r.response_bytes = 10'(pos);
                r.last_res = 1'b1;
              end
              expected_recs.push_back(r);
            end
          end
          pend_ids.delete();
          pend_ovf = 1'b0;
        end
      end
      KIND_WRITE: begin
        s = lookup_slot(it.did_id);
        if (s < 0 || !tbl_wr[s] || m_session < tbl_ses[s])
          expected_recs.push_back(err_rec(STAT_RANGE, NRC_RANGE, it.did_id));
        else if (tbl_sec[s] && !m_unlock)
          expected_recs.push_back(err_rec(STAT_SECURITY, NRC_SECURITY, it.did_id));
        else if (it.byte_cnt != tbl_len[s])
          expected_recs.push_back(err_rec(STAT_LENGTH, NRC_LENGTH, it.did_id));
        else if (m_limit < 3)
          expected_recs.push_back(err_rec(STAT_TOO_LONG, NRC_NONE, it.did_id));
        else begin
          tbl_data[s] = it.data_word & mask_len(it.byte_cnt);
          r = '0;
          r.response_sid = SID_WRITE;
          r.did_id_res = it.did_id;
          r.response_bytes = WR_RESP_BYTES;
          r.last_res = 1'b1;
          expected_recs.push_back(r);
        end
      end
      default: ;
    endcase
  endtask

  // item driver: bursts with random gaps
  int burst_left;
  int gap_left;
  bit req_acc;

  always @(posedge clk_i) begin
    req_acc <= rst_ni && req_if.valid && req_if.ready;
  end

  always @(negedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_if.valid <= 1'b0;
      req_if.item <= '0;
      burst_left <= 0;
      gap_left <= 0;
    end else begin
      if (req_acc) begin
        predict_item(req_if.item);
        void'(pending_items.pop_front());
      end
      if (req_if.valid && !req_acc) begin
        // hold the offered transfer until it is taken
      end else if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        req_if.valid <= 1'b0;
      end else if (pending_items.size() > 0) begin
        req_if.valid <= 1'b1;
        req_if.item <= pending_items[0];
        if (burst_left == 0) begin
          burst_left <= $urandom_range(1, 8);
          gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        req_if.valid <= 1'b0;
      end
    end
  end

  // receiver stall pattern: phase-shifted windows
  int stall_phase;
  always @(negedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_if.ready <= 1'b0;
      stall_phase <= 0;
    end else begin
      stall_phase <= stall_phase + 1;
      if (stall_phase % 200 < 60) rsp_if.ready <= 1'b1;
      else rsp_if.ready <= ($urandom_range(0, 3) != 0) && (stall_phase % 7 != 3);
    end
  end

  // monitor and watchdog
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready) ||
          (cfg_if.valid && cfg_if.ready))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
      if (rsp_if.valid && rsp_if.ready) begin
        if (expected_recs.size() == 0) begin
          stray++;
          if (mismatches + stray <= 10)
            $display("unexpected record: %p", rsp_if.res);
        end else begin
          if (rsp_if.res !== expected_recs[0]) begin
            mismatches++;
            if (mismatches + stray <= 10)
              $display("record mismatch: expected %p actual %p",
                       expected_recs[0], rsp_if.res);
          end
          void'(expected_recs.pop_front());
        end
      end
    end
  end

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
    @(negedge clk_i);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.wdata <= val;
    do @(posedge clk_i); while (!cfg_if.ready);
    case (idx)
      CFG_ENTRIES:  m_entries = val[4:0];
      CFG_SESSION:  m_session = val[7:0];
      CFG_SECURITY: m_unlock = val[0];
      default:      m_limit = val[9:0];
    endcase
    @(negedge clk_i);
    cfg_if.valid <= 1'b0;
  endtask

  task automatic settle();
    wait (pending_items.size() == 0 && !req_if.valid);
    wait (expected_recs.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  function automatic item_t mk(input kind_e k, input logic [3:0] sl, input logic [15:0] id,
                               input logic [3:0] len, input logic [63:0] d,
                               input bit wr, input logic [7:0] ses, input bit sec,
                               input bit lst);
    item_t it;
    it.kind = k; it.slot = sl; it.did_id = id; it.byte_cnt = len; it.data_word = d;
    it.writable = wr; it.min_session = ses; it.needs_security = sec; it.last = lst;
    return it;
  endfunction

  function automatic logic [63:0] rnd64();
    return {$urandom, $urandom};
  endfunction

  // random traffic: mostly define, read and write items over a small id pool
  task automatic random_phase(input int count);
    logic [15:0] pool [4];
    int n;
    item_t it;
    pool[0] = 16'($urandom); pool[1] = 16'($urandom); pool[2] = 16'hFFFF;
    pool[3] = 16'h0000;
    for (int i = 0; i < count; i++) begin
      it = mk(kind_e'($urandom_range(0, 3)), 4'($urandom), 16'($urandom), 4'($urandom),
              rnd64(), 1'($urandom), 8'($urandom), 1'($urandom), 1'($urandom));
      case ($urandom_range(0, 9))
        0, 1, 2: begin
          it.kind = KIND_DEFINE;
          it.did_id = pool[$urandom_range(0, 3)];
          if ($urandom_range(0, 3) != 0) it.byte_cnt = 4'($urandom_range(0, 8));
          if ($urandom_range(0, 1)) it.min_session = 8'($urandom_range(0, 3));
        end
        3, 4, 5: begin
          n = ($urandom_range(0, 9) == 0) ? $urandom_range(15, 18) : $urandom_range(1, 4);
          for (int j = 0; j < n; j++) begin
            it.kind = KIND_READ;
            it.did_id = ($urandom_range(0, 7) == 0) ? 16'($urandom) : pool[$urandom_range(0, 3)];
            it.last = (j == n - 1);
            it.data_word = rnd64();
            pending_items.push_back(it);
          end
          continue;
        end
        6, 7, 8: begin
          it.kind = KIND_WRITE;
          it.did_id = pool[$urandom_range(0, 3)];
          if ($urandom_range(0, 3) != 0) it.byte_cnt = 4'($urandom_range(0, 8));
        end
        default: ;
      endcase
      pending_items.push_back(it);
    end
  endtask

  initial begin
    req_if.valid = 1'b0;
    req_if.item = '0;
    rsp_if.ready = 1'b0;
    cfg_if.valid = 1'b0;
    cfg_if.index = CFG_ENTRIES;
    cfg_if.wdata = '0;
    mismatches = 0;
    stray = 0;
    idle_cycles = 0;
    items_done = 1'b0;
    for (int i = 0; i < 16; i++) begin
      tbl_id[i] = '0; tbl_data[i] = '0; tbl_len[i] = '0;
      tbl_wr[i] = '0; tbl_ses[i] = '0; tbl_sec[i] = '0;
    end
    pend_ovf = 1'b0;
    m_entries = 5'd0; m_session = 8'd1; m_unlock = 1'b0; m_limit = 10'd1023;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed: empty table, then defines (one clamped to full width), range, length and limit write checks
    pending_items.push_back(mk(KIND_READ, 0, 16'h0000, 0, 0, 0, 0, 0, 1));
    settle();
    write_reg(CFG_ENTRIES, 31);
    write_reg(CFG_SESSION, 255);
    write_reg(CFG_SECURITY, 1);
    write_reg(CFG_LIMIT, 1023);
    pending_items.push_back(mk(KIND_DEFINE, 0, 16'hF190, 4'hF, '1, 1, 8'hFF, 1, 0));
    pending_items.push_back(mk(KIND_DEFINE, 15, 16'hFFFF, 3, '1, 1, 0, 0, 0));
    pending_items.push_back(mk(KIND_DEFINE, 1, 16'hF190, 2, 64'h55, 1, 0, 0, 0));
    pending_items.push_back(mk(KIND_DEFINE, 2, 16'h1234, 0, '1, 0, 0, 0, 0));
    pending_items.push_back(mk(KIND_READ, 0, 16'hF190, 0, 0, 0, 0, 0, 0));
    pending_items.push_back(mk(KIND_WRITE, 0, 16'hAAAA, 8, 0, 0, 0, 0, 0));
    pending_items.push_back(mk(KIND_READ, 0, 16'hFFFF, 0, 0, 0, 0, 0, 1));
    pending_items.push_back(mk(KIND_READ, 0, 16'h0BAD, 0, 0, 0, 0, 0, 1));
    pending_items.push_back(mk(KIND_WRITE, 0, 16'hF190, 8, 64'h0123456789ABCDEF, 0, 0, 0, 0));
    pending_items.push_back(mk(KIND_WRITE, 0, 16'hF190, 7, 0, 0, 0, 0, 0));
    pending_items.push_back(mk(KIND_WRITE, 0, 16'h1234, 0, 0, 0, 0, 0, 0));
    pending_items.push_back(mk(KIND_WRITE, 0, 16'hFFFF, 3, '1, 0, 0, 0, 0));
    pending_items.push_back(mk(KIND_NONE, 0, 16'hFFFF, 0, 0, 0, 0, 0, 1));
    for (int j = 0; j < 17; j++)
      pending_items.push_back(mk(KIND_READ, 0, 16'hF190, 0, 0, 0, 0, 0, j == 16));
    settle();
    write_reg(CFG_SECURITY, 0);
    write_reg(CFG_SESSION, 0);
    write_reg(CFG_LIMIT, 2);
    pending_items.push_back(mk(KIND_WRITE, 0, 16'hF190, 8, 0, 0, 0, 0, 0));
    pending_items.push_back(mk(KIND_WRITE, 0, 16'hFFFF, 3, 0, 0, 0, 0, 0));
    pending_items.push_back(mk(KIND_READ, 0, 16'hFFFF, 0, 0, 0, 0, 0, 1));
    settle();
    write_reg(CFG_LIMIT, 0);
    pending_items.push_back(mk(KIND_READ, 0, 16'hFFFF, 0, 0, 0, 0, 0, 1));
    settle();

    for (int ph = 0; ph < 4; ph++) begin
      write_reg(CFG_ENTRIES, (ph == 0) ? 16 : $urandom_range(0, 17));
      write_reg(CFG_SESSION, (ph == 1) ? 0 : $urandom_range(0, 4));
      write_reg(CFG_SECURITY, 32'(ph[0]));
      write_reg(CFG_LIMIT, (ph == 3) ? $urandom_range(0, 30) : 1023);
      random_phase(18);
      settle();
    end
    items_done = 1'b1;

    if (mismatches == 0 && stray == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  always @(posedge clk_i) begin
    if (idle_cycles >= STALL_LIMIT && !items_done) begin
      $display("CHECK FAILED");
      $finish;
    end
  end
endmodule
